// ===== rtl/pascal_subset_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tokenizer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PASCAL_SUBSET_TOKENIZER_DEFINES_SVH
`define PASCAL_SUBSET_TOKENIZER_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define PST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define PST_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// Tokenizer package
// Types, token codes, character constants and keyword table.
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int NUM_KW     = 20;
	localparam int TEXT_LEN_W = 6;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = 2;

	localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

	localparam logic [5:0] KIND_UNKNOWN = 6'd0;
	localparam logic [5:0] KIND_IDENT   = 6'd1;
	localparam logic [5:0] KIND_NUMBER  = 6'd2;
	localparam logic [5:0] KIND_CHAR    = 6'd3;
	localparam logic [5:0] KIND_STRING  = 6'd4;
	localparam logic [5:0] KIND_KW0     = 6'd5;
	localparam logic [5:0] KIND_ASSIGN  = 6'd25;
	localparam logic [5:0] KIND_COLON   = 6'd26;
	localparam logic [5:0] KIND_COMMA   = 6'd27;
	localparam logic [5:0] KIND_SLASH   = 6'd28;
	localparam logic [5:0] KIND_EQ      = 6'd29;
	localparam logic [5:0] KIND_GT      = 6'd30;
	localparam logic [5:0] KIND_LBRACK  = 6'd31;
	localparam logic [5:0] KIND_LT      = 6'd32;
	localparam logic [5:0] KIND_LPAREN  = 6'd33;
	localparam logic [5:0] KIND_MINUS   = 6'd34;
	localparam logic [5:0] KIND_GE      = 6'd35;
	localparam logic [5:0] KIND_LE      = 6'd36;
	localparam logic [5:0] KIND_NE      = 6'd37;
	localparam logic [5:0] KIND_DOT     = 6'd38;
	localparam logic [5:0] KIND_PLUS    = 6'd39;
	localparam logic [5:0] KIND_RBRACK  = 6'd40;
	localparam logic [5:0] KIND_RPAREN  = 6'd41;
	localparam logic [5:0] KIND_SEMI    = 6'd42;
	localparam logic [5:0] KIND_STAR    = 6'd43;
	localparam logic [5:0] KIND_ERROR   = 6'd44;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;

	// Keyword spellings, right aligned: the first letter is the highest byte of the spelling.
	localparam logic [79:0] KW_TEXT [NUM_KW] = '{
		"array", "begin", "case", "char", "const", "do", "downto", "else", "end", "for",
		"function", "if", "integer", "of", "procedure", "read", "then", "to", "var", "write"
	};
	localparam int KW_LEN [NUM_KW] = '{5, 5, 4, 4, 5, 2, 6, 4, 3, 3, 8, 2, 7, 2, 9, 4, 4, 2, 3, 5};

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_CHAR_OPEN,
		MODE_CHAR_CLOSE,
		MODE_STRING,
		MODE_COLON,
		MODE_LESS,
		MODE_GREATER
	} pst_mode_t;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} pst_back_state_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_input;
	} pst_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [30:0] number_value;
		logic [7:0]  text_char;
		logic [4:0]  text_position;
		logic        last_of_token;
		logic [15:0] line_number;
		logic        overflow_flag;
	} pst_result_t;

	// One finished token on its way from the scanner to the emitter.
	typedef struct packed {
		logic [5:0]            kind;
		logic [30:0]           value;
		logic                  ovf;
		logic [15:0]           line;
		logic                  use_mem;
		logic [TEXT_LEN_W-1:0] len;
		logic [7:0]            ch;
		logic                  bank;
	} pst_desc_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// Single-character operator code, or KIND_UNKNOWN when c is not one.
	function automatic logic [5:0] op_kind(input logic [7:0] c);
		logic [5:0] k;
		unique case (c)
			8'h2C:   k = KIND_COMMA;
			8'h2F:   k = KIND_SLASH;
			8'h3D:   k = KIND_EQ;
			8'h5B:   k = KIND_LBRACK;
			8'h28:   k = KIND_LPAREN;
			8'h2D:   k = KIND_MINUS;
			8'h2E:   k = KIND_DOT;
			8'h2B:   k = KIND_PLUS;
			8'h5D:   k = KIND_RBRACK;
			8'h29:   k = KIND_RPAREN;
			8'h3B:   k = KIND_SEMI;
			8'h2A:   k = KIND_STAR;
			default: k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	// Narrows the keyword candidates by the character placed at position pos.
	function automatic logic [NUM_KW-1:0] kw_step(input logic [NUM_KW-1:0] m,
			input logic [TEXT_LEN_W-1:0] pos, input logic [7:0] c);
		logic [NUM_KW-1:0] r;
		int sh;
		for (int i = 0; i < NUM_KW; i++) begin
			sh = KW_LEN[i] - 1 - int'(pos);
			if (int'(pos) < KW_LEN[i]) begin
				r[i] = m[i] && (KW_TEXT[i][8*sh +: 8] == c);
			end else begin
				r[i] = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic pst_desc_t mk_desc(input logic [5:0] kind, input logic [30:0] value,
			input logic ovf, input logic [15:0] line, input logic use_mem,
			input logic [TEXT_LEN_W-1:0] len, input logic [7:0] ch, input logic bank);
		pst_desc_t d;
		d.kind    = kind;
		d.value   = value;
		d.ovf     = ovf;
		d.line    = line;
		d.use_mem = use_mem;
		d.len     = len;
		d.ch      = ch;
		d.bank    = bank;
		return d;
	endfunction

endpackage

// ===== rtl/pst_queue.sv =====
// ----------------------------------------------------------------------------
// Token queue
// Four-entry queue between scanner and emitter; takes up to two tokens a cycle.
// ----------------------------------------------------------------------------
`include "pascal_subset_tokenizer_defines.svh"

module pst_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_a,
	input  logic                push_b,
	input  pst_pkg::pst_desc_t  desc_a,
	input  pst_pkg::pst_desc_t  desc_b,
	input  logic                head_pop,
	output pst_pkg::pst_desc_t  head,
	output logic                head_valid,
	output logic                room2
);

	pst_pkg::pst_desc_t              entries_q [pst_pkg::Q_DEPTH];
	logic [pst_pkg::Q_PTR_W-1:0]     wp_q;
	logic [pst_pkg::Q_PTR_W-1:0]     rp_q;
	logic [pst_pkg::Q_PTR_W:0]       count_q;
	logic [pst_pkg::Q_PTR_W-1:0]     wp_b;

	assign wp_b       = wp_q + 1'b1;
	assign head       = entries_q[rp_q];
	assign head_valid = (count_q != '0);
	assign room2      = (count_q <= (pst_pkg::Q_PTR_W+1)'(pst_pkg::Q_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_a) begin
			entries_q[wp_q] <= desc_a;
		end
		if (push_b) begin
			entries_q[wp_b] <= desc_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + pst_pkg::Q_PTR_W'(push_a) + pst_pkg::Q_PTR_W'(push_b);
			rp_q    <= rp_q + pst_pkg::Q_PTR_W'(head_pop);
			count_q <= count_q + (pst_pkg::Q_PTR_W+1)'(push_a) + (pst_pkg::Q_PTR_W+1)'(push_b)
				- (pst_pkg::Q_PTR_W+1)'(head_pop);
		end
	end

	`PST_NEVER(a_q_overflow, count_q > (pst_pkg::Q_PTR_W+1)'(pst_pkg::Q_DEPTH), "token queue overflow")
	`PST_ASSERT(a_q_b_after_a, push_b |-> push_a, "second token pushed without first")
	`PST_ASSERT(a_q_pop_nonempty, head_pop |-> (count_q != '0), "pop from empty token queue")

endmodule

// ===== rtl/pst_front.sv =====
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Takes source characters, tracks the scan mode and issues finished tokens.
// ----------------------------------------------------------------------------
module pst_front #(
	parameter int MAX_TEXT  = 32,
	parameter int LINE_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  pst_pkg::pst_item_t       item,
	output logic                     full,
	input  logic                     room2,
	input  logic                     buf_done,
	output logic                     push_a,
	output logic                     push_b,
	output pst_pkg::pst_desc_t       desc_a,
	output pst_pkg::pst_desc_t       desc_b,
	output logic                     mem_we,
	output logic [$clog2(MAX_TEXT):0] mem_waddr,
	output logic [7:0]               mem_wdata
);

	localparam int IDX_W = $clog2(MAX_TEXT);
	localparam int LW    = pst_pkg::TEXT_LEN_W;

	pst_pkg::pst_mode_t         mode_q, mode_n;
	logic [LW-1:0]              len_q, len_n;
	logic                       cut_q, cut_n;
	logic [30:0]                acc_q, acc_n;
	logic                       sat_q, sat_n;
	logic [LINE_BITS-1:0]       line_q, line_n;
	logic [LINE_BITS-1:0]       start_q, start_n;
	logic                       halt_q, halt_n;
	logic                       bank_q, bank_n;
	logic [pst_pkg::NUM_KW-1:0] kwm_q, kwm_n;
	logic                       busy_q, busy_n;

	logic                       accept;
	logic [7:0]                 c;
	logic [pst_pkg::NUM_KW-1:0] kw_hit;
	logic [5:0]                 kw_kind;
	pst_pkg::pst_desc_t         ident_tok;
	pst_pkg::pst_desc_t         num_tok;
	pst_pkg::pst_desc_t         ft, bt;
	logic                       fv, bv, do_begin;
	logic [34:0]                acc_x10;
	logic [5:0]                 opk;

	function automatic logic [15:0] line16(input logic [LINE_BITS-1:0] x);
		logic [31:0] t;
		t = 32'(x);
		return t[15:0];
	endfunction

	assign full   = busy_q || !room2;
	assign accept = push && !full;
	assign c      = item.char_in;
	assign opk    = pst_pkg::op_kind(c);

	always_comb begin
		kw_kind = pst_pkg::KIND_KW0;
		for (int i = 0; i < pst_pkg::NUM_KW; i++) begin
			kw_hit[i] = kwm_q[i] && (len_q == LW'(pst_pkg::KW_LEN[i]));
			if (kw_hit[i]) begin
				kw_kind = pst_pkg::KIND_KW0 + 6'(i);
			end
		end
	end

	// An identifier that was cut never becomes a keyword.
	always_comb begin
		if (!cut_q && (kw_hit != '0)) begin
			ident_tok = pst_pkg::mk_desc(kw_kind, '0, 1'b0, line16(start_q), 1'b0, '0, '0,
				bank_q);
		end else begin
			ident_tok = pst_pkg::mk_desc(pst_pkg::KIND_IDENT, '0, cut_q, line16(start_q), 1'b1,
				len_q, '0, bank_q);
		end
		num_tok = pst_pkg::mk_desc(pst_pkg::KIND_NUMBER, acc_q, sat_q, line16(start_q), 1'b0,
			'0, '0, bank_q);
	end

	assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 35'(c - pst_pkg::CH_ZERO);

	always_comb begin
		mode_n    = mode_q;
		len_n     = len_q;
		cut_n     = cut_q;
		acc_n     = acc_q;
		sat_n     = sat_q;
		line_n    = line_q;
		start_n   = start_q;
		halt_n    = halt_q;
		bank_n    = bank_q;
		kwm_n     = kwm_q;
		busy_n    = busy_q && !buf_done;
		mem_we    = 1'b0;
		mem_waddr = {bank_q, len_q[IDX_W-1:0]};
		mem_wdata = c;
		fv        = 1'b0;
		ft        = ident_tok;
		bv        = 1'b0;
		bt        = ident_tok;
		do_begin  = 1'b0;

		if (accept) begin
			if (item.end_of_input) begin
				if (!halt_q) begin
					case (mode_q) inside
						pst_pkg::MODE_IDENT: begin
							fv = 1'b1;
							ft = ident_tok;
						end
						pst_pkg::MODE_NUMBER: begin
							fv = 1'b1;
							ft = num_tok;
						end
						pst_pkg::MODE_CHAR_OPEN, pst_pkg::MODE_CHAR_CLOSE,
						pst_pkg::MODE_STRING: begin
							fv = 1'b1;
							ft = pst_pkg::mk_desc(pst_pkg::KIND_ERROR, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
						end
						pst_pkg::MODE_COLON: begin
							fv = 1'b1;
							ft = pst_pkg::mk_desc(pst_pkg::KIND_COLON, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
						end
						pst_pkg::MODE_LESS: begin
							fv = 1'b1;
							ft = pst_pkg::mk_desc(pst_pkg::KIND_LT, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
						end
						pst_pkg::MODE_GREATER: begin
							fv = 1'b1;
							ft = pst_pkg::mk_desc(pst_pkg::KIND_GT, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
						end
						default: begin
						end
					endcase
				end
				mode_n  = pst_pkg::MODE_IDLE;
				len_n   = '0;
				cut_n   = 1'b0;
				acc_n   = '0;
				sat_n   = 1'b0;
				line_n  = LINE_BITS'(1);
				start_n = LINE_BITS'(1);
				halt_n  = 1'b0;
			end else if (!halt_q) begin
				case (mode_q)
					pst_pkg::MODE_IDENT: begin
						if (pst_pkg::is_letter(c) || pst_pkg::is_digit(c)) begin
							if (len_q < LW'(MAX_TEXT)) begin
								mem_we = 1'b1;
								len_n  = len_q + 1'b1;
								kwm_n  = pst_pkg::kw_step(kwm_q, len_q, c);
							end else begin
								cut_n = 1'b1;
							end
						end else begin
							fv       = 1'b1;
							ft       = ident_tok;
							do_begin = 1'b1;
						end
					end
					pst_pkg::MODE_NUMBER: begin
						if (pst_pkg::is_digit(c)) begin
							if (!sat_q) begin
								if (acc_x10 > 35'(pst_pkg::NUM_MAX)) begin
									acc_n = pst_pkg::NUM_MAX;
									sat_n = 1'b1;
								end else begin
									acc_n = acc_x10[30:0];
								end
							end
						end else begin
							fv       = 1'b1;
							ft       = num_tok;
							do_begin = 1'b1;
						end
					end
					pst_pkg::MODE_CHAR_OPEN: begin
						mem_we = 1'b1;
						len_n  = len_q + 1'b1;
						mode_n = pst_pkg::MODE_CHAR_CLOSE;
					end
					pst_pkg::MODE_CHAR_CLOSE: begin
						mode_n = pst_pkg::MODE_IDLE;
						fv     = 1'b1;
						if (c == pst_pkg::CH_QUOTE) begin
							ft = pst_pkg::mk_desc(pst_pkg::KIND_CHAR, '0, 1'b0, line16(start_q),
								1'b1, len_q, '0, bank_q);
						end else begin
							ft = pst_pkg::mk_desc(pst_pkg::KIND_ERROR, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
							halt_n = 1'b1;
						end
					end
					pst_pkg::MODE_STRING: begin
						if (c == pst_pkg::CH_DQUOTE) begin
							mode_n = pst_pkg::MODE_IDLE;
							fv     = 1'b1;
							ft     = pst_pkg::mk_desc(pst_pkg::KIND_STRING, '0, cut_q,
								line16(start_q), len_q != '0, len_q, '0, bank_q);
						end else if (len_q < LW'(MAX_TEXT)) begin
							mem_we = 1'b1;
							len_n  = len_q + 1'b1;
						end else begin
							cut_n = 1'b1;
						end
					end
					pst_pkg::MODE_COLON: begin
						mode_n = pst_pkg::MODE_IDLE;
						fv     = 1'b1;
						if (c == pst_pkg::CH_EQ) begin
							ft = pst_pkg::mk_desc(pst_pkg::KIND_ASSIGN, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
						end else begin
							ft = pst_pkg::mk_desc(pst_pkg::KIND_COLON, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
							do_begin = 1'b1;
						end
					end
					pst_pkg::MODE_LESS: begin
						mode_n = pst_pkg::MODE_IDLE;
						fv     = 1'b1;
						if (c == pst_pkg::CH_EQ) begin
							ft = pst_pkg::mk_desc(pst_pkg::KIND_LE, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
						end else if (c == pst_pkg::CH_GT) begin
							ft = pst_pkg::mk_desc(pst_pkg::KIND_NE, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
						end else begin
							ft = pst_pkg::mk_desc(pst_pkg::KIND_LT, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
							do_begin = 1'b1;
						end
					end
					pst_pkg::MODE_GREATER: begin
						mode_n = pst_pkg::MODE_IDLE;
						fv     = 1'b1;
						if (c == pst_pkg::CH_EQ) begin
							ft = pst_pkg::mk_desc(pst_pkg::KIND_GE, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
						end else begin
							ft = pst_pkg::mk_desc(pst_pkg::KIND_GT, '0, 1'b0,
								line16(start_q), 1'b0, '0, '0, bank_q);
							do_begin = 1'b1;
						end
					end
					default: begin
						do_begin = 1'b1;
					end
				endcase

				// A new token starts in the other text bank, so the emitter may still
				// read the previous token's text while this one is written.
				if (do_begin) begin
					mode_n  = pst_pkg::MODE_IDLE;
					start_n = line_q;
					len_n   = '0;
					cut_n   = 1'b0;
					bank_n  = ~bank_q;
					if (pst_pkg::is_letter(c)) begin
						mem_we    = 1'b1;
						mem_waddr = {~bank_q, IDX_W'(0)};
						len_n     = LW'(1);
						kwm_n     = pst_pkg::kw_step('1, '0, c);
						mode_n    = pst_pkg::MODE_IDENT;
					end else if (pst_pkg::is_digit(c)) begin
						acc_n  = 31'(c - pst_pkg::CH_ZERO);
						sat_n  = 1'b0;
						mode_n = pst_pkg::MODE_NUMBER;
					end else if (c == pst_pkg::CH_QUOTE) begin
						mode_n = pst_pkg::MODE_CHAR_OPEN;
					end else if (c == pst_pkg::CH_DQUOTE) begin
						mode_n = pst_pkg::MODE_STRING;
					end else if (c == pst_pkg::CH_COLON) begin
						mode_n = pst_pkg::MODE_COLON;
					end else if (c == pst_pkg::CH_LT) begin
						mode_n = pst_pkg::MODE_LESS;
					end else if (c == pst_pkg::CH_GT) begin
						mode_n = pst_pkg::MODE_GREATER;
					end else if (opk != pst_pkg::KIND_UNKNOWN) begin
						bv = 1'b1;
						bt = pst_pkg::mk_desc(opk, '0, 1'b0, line16(line_q), 1'b0, '0, '0,
							bank_q);
					end else if (c != pst_pkg::CH_SPACE && c != pst_pkg::CH_TAB
							&& c != pst_pkg::CH_NL) begin
						// The unknown character travels inside the token itself.
						bv = 1'b1;
						bt = pst_pkg::mk_desc(pst_pkg::KIND_UNKNOWN, '0, 1'b0, line16(line_q),
							1'b0, LW'(1), c, bank_q);
					end
				end

				if (c == pst_pkg::CH_NL && line_q != '1) begin
					line_n = line_q + 1'b1;
				end
			end
		end

		if ((fv && ft.use_mem) || (bv && bt.use_mem)) begin
			busy_n = 1'b1;
		end
	end

	always_comb begin
		push_a = fv || bv;
		push_b = fv && bv;
		desc_a = fv ? ft : bt;
		desc_b = bt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= pst_pkg::MODE_IDLE;
			len_q   <= '0;
			cut_q   <= 1'b0;
			acc_q   <= '0;
			sat_q   <= 1'b0;
			line_q  <= LINE_BITS'(1);
			start_q <= LINE_BITS'(1);
			halt_q  <= 1'b0;
			bank_q  <= 1'b0;
			kwm_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			mode_q  <= mode_n;
			len_q   <= len_n;
			cut_q   <= cut_n;
			acc_q   <= acc_n;
			sat_q   <= sat_n;
			line_q  <= line_n;
			start_q <= start_n;
			halt_q  <= halt_n;
			bank_q  <= bank_n;
			kwm_q   <= kwm_n;
			busy_q  <= busy_n;
		end
	end

endmodule

// ===== rtl/pst_back.sv =====
// ----------------------------------------------------------------------------
// Tokenizer emitter
// Holds the text memory and sends each token one text character per result.
// ----------------------------------------------------------------------------
module pst_back #(
	parameter int MAX_TEXT = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pst_pkg::pst_desc_t        head,
	input  logic                      head_valid,
	output logic                      head_pop,
	input  logic                      mem_we,
	input  logic [$clog2(MAX_TEXT):0] mem_waddr,
	input  logic [7:0]                mem_wdata,
	output logic                      buf_done,
	input  logic                      pop,
	output logic                      empty,
	output pst_pkg::pst_result_t      result
);

	localparam int IDX_W  = $clog2(MAX_TEXT);
	localparam int ADDR_W = IDX_W + 1;
	localparam int LW     = pst_pkg::TEXT_LEN_W;

	logic [7:0]                 mem [2**ADDR_W];
	logic [7:0]                 rdata_q;
	logic [ADDR_W-1:0]          raddr;

	pst_pkg::pst_back_state_t   state_q, state_n;
	pst_pkg::pst_desc_t         cur_q;
	logic [LW-1:0]              k_q;
	logic [LW-1:0]              k_inc;
	logic [LW-1:0]              nres;
	logic                       last;
	logic                       slot_free;
	logic                       load;
	logic                       adv;
	logic [7:0]                 text;
	pst_pkg::pst_result_t       res_q;
	logic                       res_v_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign k_inc     = k_q + 1'b1;
	assign nres      = (cur_q.len == '0) ? LW'(1) : cur_q.len;
	assign last      = (k_inc == nres);
	assign slot_free = !res_v_q || pop;
	assign text      = cur_q.use_mem ? rdata_q : cur_q.ch;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			pst_pkg::BK_IDLE: begin
				if (head_valid) begin
					state_n = pst_pkg::BK_EMIT;
				end
			end
			pst_pkg::BK_EMIT: begin
				if (slot_free && last) begin
					state_n = pst_pkg::BK_IDLE;
				end
			end
			default: state_n = pst_pkg::BK_IDLE;
		endcase
	end

	// The read address runs one step ahead so the character is ready when the
	// output register has room.
	always_comb begin
		head_pop = 1'b0;
		load     = 1'b0;
		adv      = 1'b0;
		buf_done = 1'b0;
		raddr    = {head.bank, IDX_W'(0)};
		unique case (state_q)
			pst_pkg::BK_IDLE: begin
				head_pop = head_valid;
			end
			pst_pkg::BK_EMIT: begin
				load     = slot_free;
				adv      = slot_free && !last;
				buf_done = slot_free && last && cur_q.use_mem;
				raddr    = {cur_q.bank, adv ? k_inc[IDX_W-1:0] : k_q[IDX_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			cur_q <= head;
		end
		if (load) begin
			res_q.token_kind    <= cur_q.kind;
			res_q.number_value  <= cur_q.value;
			res_q.text_char     <= text;
			res_q.text_position <= k_q[4:0];
			res_q.last_of_token <= last;
			res_q.line_number   <= cur_q.line;
			res_q.overflow_flag <= cur_q.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pst_pkg::BK_IDLE;
			k_q     <= '0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (head_pop) begin
				k_q <= '0;
			end else if (adv) begin
				k_q <= k_inc;
			end
			if (load) begin
				res_v_q <= 1'b1;
			end else if (pop) begin
				res_v_q <= 1'b0;
			end
		end
	end

	assign empty  = !res_v_q;
	assign result = res_q;

endmodule

// ===== rtl/pascal_subset_tokenizer.sv =====
// A finished token goes via the queue and the emitter's token register to the output register.
// Throughput: one character per cycle while the queue has room for two tokens; after a token
// with text, input holds until the emitter has read its last character from the text memory.
// Results leave at one per cycle within a token while pop keeps up; between tokens the emitter
// passes through its idle state while it takes the next token from the queue.
// Reset is asynchronous and needs no clearing pass; the block takes input right after it.
// ----------------------------------------------------------------------------
// Pascal subset tokenizer
// Scanner and emitter joined by a short token queue; results leave one text
// character at a time through a registered output.
// ----------------------------------------------------------------------------
module pascal_subset_tokenizer #(
	parameter int MAX_TEXT  = 32,
	parameter int LINE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pst_pkg::pst_item_t   item,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output pst_pkg::pst_result_t result
);

	logic                      room2;
	logic                      buf_done;
	logic                      push_a;
	logic                      push_b;
	pst_pkg::pst_desc_t        desc_a;
	pst_pkg::pst_desc_t        desc_b;
	pst_pkg::pst_desc_t        head;
	logic                      head_valid;
	logic                      head_pop;
	logic                      mem_we;
	logic [$clog2(MAX_TEXT):0] mem_waddr;
	logic [7:0]                mem_wdata;

	pst_front #(
		.MAX_TEXT  (MAX_TEXT),
		.LINE_BITS (LINE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.room2     (room2),
		.buf_done  (buf_done),
		.push_a    (push_a),
		.push_b    (push_b),
		.desc_a    (desc_a),
		.desc_b    (desc_b),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	pst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_a     (push_a),
		.push_b     (push_b),
		.desc_a     (desc_a),
		.desc_b     (desc_b),
		.head_pop   (head_pop),
		.head       (head),
		.head_valid (head_valid),
		.room2      (room2)
	);

	pst_back #(
		.MAX_TEXT (MAX_TEXT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.buf_done   (buf_done),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule
